FILE: rtl/core/ugl_pkg.sv
// Shared types and constants of the uniform grid linear resampler.
`timescale 1ns / 1ps

package ugl_pkg;

    localparam int TIME_W    = 32;
    localparam int GRID_W    = 33;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_TIME      = 2'd2;

    localparam logic [TIME_W-1:0] RESET_SAMPLE_PERIOD = 32'd1000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REL,
        S_LIM,
        S_OVER,
        S_CHECK,
        S_CALC,
        S_EMIT,
        S_REM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic calc_rel;
        logic calc_lim;
        logic calc_over;
        logic lane_start;
        logic emit;
        logic rem_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic point_ok;
        logic need_interp;
        logic lanes_done;
        logic emit_ok;
        logic rem_needed;
        logic rem_done;
    } t_status;

endpackage

FILE: rtl/core/ugl_sample_if.sv
// Input sample channel of the resampler.
`timescale 1ns / 1ps

interface ugl_sample_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                            valid;
    logic                            ready;
    logic [ugl_pkg::TIME_W-1:0]      stamp;
    logic signed [VALUE_WIDTH-1:0]   chan_a;
    logic signed [VALUE_WIDTH-1:0]   chan_b;
    logic signed [VALUE_WIDTH-1:0]   chan_c;
    logic                            end_of_stream;

    modport source (output valid, stamp, chan_a, chan_b, chan_c, end_of_stream,
                    input ready);
    modport sink (input valid, stamp, chan_a, chan_b, chan_c, end_of_stream,
                  output ready);
endinterface

FILE: rtl/core/ugl_result_if.sv
// Result channel of the resampler.
`timescale 1ns / 1ps

interface ugl_result_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                            valid;
    logic                            ready;
    logic [ugl_pkg::TIME_W-1:0]      grid_time;
    logic signed [VALUE_WIDTH-1:0]   out_a;
    logic signed [VALUE_WIDTH-1:0]   out_b;
    logic signed [VALUE_WIDTH-1:0]   out_c;
    logic                            last_of_run;
    logic                            burst_overflow;

    modport source (output valid, grid_time, out_a, out_b, out_c, last_of_run,
                    burst_overflow, input ready);
    modport sink (input valid, grid_time, out_a, out_b, out_c, last_of_run,
                  burst_overflow, output ready);
endinterface

FILE: rtl/core/ugl_cfg_if.sv
// Configuration write channel of the resampler.
`timescale 1ns / 1ps

interface ugl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ugl_pkg::CFG_IDX_W-1:0]  index;
    logic [ugl_pkg::TIME_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ugl_lane.sv
// Bit-serial rounded multiply-divide lane for one interpolated channel.
`timescale 1ns / 1ps

module ugl_lane #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [VALUE_WIDTH-1:0]        i_v0,
    input  logic [VALUE_WIDTH-1:0]        i_v1,
    input  logic [ugl_pkg::TIME_W-1:0]    i_dt,
    input  logic [ugl_pkg::TIME_W-1:0]    i_den,
    output logic                          o_done,
    output logic [VALUE_WIDTH-1:0]        o_res
);
    localparam int CNW = $clog2(VALUE_WIDTH + 1);
    localparam int TW  = ugl_pkg::TIME_W;

    logic                   r_busy;
    logic [CNW-1:0]         r_cnt;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_v0;
    logic [TW-1:0]          r_dt;
    logic [TW-1:0]          r_den;
    logic [TW-1:0]          r_rem;
    logic [VALUE_WIDTH-1:0] r_q;
    logic [VALUE_WIDTH-1:0] r_res;

    logic [VALUE_WIDTH:0]   diff;
    logic [VALUE_WIDTH:0]   ndiff;
    logic [TW+1:0]          x;
    logic [TW+1:0]          d1;
    logic [TW+1:0]          d2;
    logic [TW+1:0]          n_rem;
    logic [1:0]             digit;
    logic                   rnd;
    logic [VALUE_WIDTH-1:0] qr;

    always_comb begin
        diff  = {i_v1[VALUE_WIDTH-1], i_v1} - {i_v0[VALUE_WIDTH-1], i_v0};
        ndiff = -diff;
        x     = {1'b0, r_rem, 1'b0} + (r_mag[VALUE_WIDTH-1] ? {2'b00, r_dt} : '0);
        d1    = {2'b00, r_den};
        d2    = {1'b0, r_den, 1'b0};
        if (x >= d2) begin
            digit = 2'd2;
            n_rem = x - d2;
        end else if (x >= d1) begin
            digit = 2'd1;
            n_rem = x - d1;
        end else begin
            digit = 2'd0;
            n_rem = x;
        end
        rnd = ({1'b0, r_rem} + {2'b00, r_den[TW-1:1]}) >= {1'b0, r_den};
        qr  = r_q + VALUE_WIDTH'(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNW'(VALUE_WIDTH);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= diff[VALUE_WIDTH];
            r_mag <= diff[VALUE_WIDTH] ? ndiff[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
            r_v0  <= i_v0;
            r_dt  <= i_dt;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
                r_rem <= n_rem[TW-1:0];
                r_q   <= {r_q[VALUE_WIDTH-2:0], 1'b0} + VALUE_WIDTH'(digit);
            end else if (r_den == '0) begin
                r_res <= r_v0;
            end else begin
                r_res <= r_neg ? r_v0 - qr : r_v0 + qr;
            end
        end
    end

    assign o_done = !r_busy;
    assign o_res  = r_res;

endmodule

FILE: rtl/core/ugl_datapath.sv
// Datapath of the resampler: registers, stream state, lanes and remainder loop.
`timescale 1ns / 1ps

module ugl_datapath #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_BURST   = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ugl_pkg::t_cmd                   i_cmd,
    output ugl_pkg::t_status                o_status,
    input  logic [ugl_pkg::TIME_W-1:0]      i_stamp,
    input  logic [VALUE_WIDTH-1:0]          i_chan_a,
    input  logic [VALUE_WIDTH-1:0]          i_chan_b,
    input  logic [VALUE_WIDTH-1:0]          i_chan_c,
    input  logic                            i_end_of_stream,
    input  logic                            i_cfg_valid,
    input  logic [ugl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ugl_pkg::TIME_W-1:0]      i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ugl_pkg::TIME_W-1:0]      o_grid_time,
    output logic [VALUE_WIDTH-1:0]          o_out_a,
    output logic [VALUE_WIDTH-1:0]          o_out_b,
    output logic [VALUE_WIDTH-1:0]          o_out_c,
    output logic                            o_last_of_run,
    output logic                            o_burst_overflow
);
    localparam int TW  = ugl_pkg::TIME_W;
    localparam int GW  = ugl_pkg::GRID_W;
    localparam int CW  = $clog2(MAX_BURST + 1);
    localparam int SPW = TW + CW;
    localparam int OW  = SPW + 1;
    localparam int RCW = $clog2(TW + 1);

    logic [TW-1:0]          r_period;
    logic [TW-1:0]          r_start;
    logic [TW-1:0]          r_end;

    logic [TW-1:0]          r_prev_stamp;
    logic [VALUE_WIDTH-1:0] r_prev_a;
    logic [VALUE_WIDTH-1:0] r_prev_b;
    logic [VALUE_WIDTH-1:0] r_prev_c;
    logic [1:0]             r_seen;
    logic [GW-1:0]          r_next_grid;

    logic [TW-1:0]          r_stamp;
    logic [VALUE_WIDTH-1:0] r_a;
    logic [VALUE_WIDTH-1:0] r_b;
    logic [VALUE_WIDTH-1:0] r_c;
    logic                   r_eos;
    logic [TW-1:0]          r_rel;
    logic [SPW-1:0]         r_span;
    logic [TW-1:0]          r_lim;
    logic                   r_have;
    logic                   r_over;
    logic [TW-1:0]          r_den;
    logic [CW-1:0]          r_n;

    logic                   r_o_valid;
    logic [TW-1:0]          r_o_time;
    logic [VALUE_WIDTH-1:0] r_o_a;
    logic [VALUE_WIDTH-1:0] r_o_b;
    logic [VALUE_WIDTH-1:0] r_o_c;
    logic                   r_o_last;
    logic                   r_o_over;

    logic                   r_rem_busy;
    logic [RCW-1:0]         r_rcnt;
    logic [TW-1:0]          r_div;
    logic [TW-1:0]          r_rem;

    logic [TW-1:0]          per_eff;
    logic [TW-1:0]          rel0;
    logic [TW-1:0]          rel;
    logic [TW-1:0]          rel_m1;
    logic [TW-1:0]          t;
    logic                   pt_ok;
    logic                   use_in;
    logic                   use_prev;
    logic [TW-1:0]          dt;
    logic                   rem_needed;
    logic                   last;
    logic [TW:0]            rem_x;
    logic                   done_a;
    logic                   done_b;
    logic                   done_c;
    logic [VALUE_WIDTH-1:0] res_a;
    logic [VALUE_WIDTH-1:0] res_b;
    logic [VALUE_WIDTH-1:0] res_c;

    always_comb begin
        per_eff    = (r_period == '0) ? TW'(1) : r_period;
        rel0       = (r_stamp < r_start) ? '0 : r_stamp - r_start;
        rel        = (r_seen != 2'd0 && rel0 < r_prev_stamp) ? r_prev_stamp : rel0;
        rel_m1     = r_rel - 1'b1;
        t          = r_next_grid[TW-1:0];
        pt_ok      = r_have && (r_n < CW'(MAX_BURST)) && (r_next_grid <= {1'b0, r_lim});
        use_in     = (r_seen == 2'd0) || (t >= r_rel);
        use_prev   = (r_seen == 2'd1);
        dt         = (t >= r_prev_stamp) ? t - r_prev_stamp : '0;
        rem_needed = !r_eos && r_have && (r_next_grid <= {1'b0, r_lim});
        last       = (r_n == CW'(MAX_BURST - 1))
                     || (({1'b0, r_next_grid} + {2'b00, per_eff}) > {2'b00, r_lim});
        rem_x      = {r_rem, r_div[TW-1]};
    end

    always_comb begin
        o_status.point_ok    = pt_ok;
        o_status.need_interp = !use_in && !use_prev;
        o_status.lanes_done  = done_a && done_b && done_c;
        o_status.emit_ok     = !r_o_valid || i_out_ready;
        o_status.rem_needed  = rem_needed;
        o_status.rem_done    = !r_rem_busy;
    end

    ugl_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.lane_start),
        .i_v0(r_prev_a), .i_v1(r_a), .i_dt(dt), .i_den(r_den),
        .o_done(done_a), .o_res(res_a)
    );

    ugl_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.lane_start),
        .i_v0(r_prev_b), .i_v1(r_b), .i_dt(dt), .i_den(r_den),
        .o_done(done_b), .o_res(res_b)
    );

    ugl_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.lane_start),
        .i_v0(r_prev_c), .i_v1(r_c), .i_dt(dt), .i_den(r_den),
        .o_done(done_c), .o_res(res_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= ugl_pkg::RESET_SAMPLE_PERIOD;
            r_start  <= '0;
            r_end    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ugl_pkg::REG_SAMPLE_PERIOD: r_period <= i_cfg_data;
                ugl_pkg::REG_START_TIME:    r_start  <= i_cfg_data;
                ugl_pkg::REG_END_TIME:      r_end    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_stamp <= '0;
            r_prev_a     <= '0;
            r_prev_b     <= '0;
            r_prev_c     <= '0;
            r_seen       <= '0;
            r_next_grid  <= '0;
            r_have       <= 1'b0;
            r_n          <= '0;
        end else begin
            if (i_cmd.calc_lim) begin
                r_n <= '0;
                if (r_eos) begin
                    r_have <= 1'b1;
                end else begin
                    r_have <= (r_seen != 2'd0) && (r_rel != '0);
                end
            end
            if (i_cmd.emit) begin
                r_next_grid <= r_next_grid + {1'b0, per_eff};
                r_n         <= r_n + 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_eos) begin
                    r_prev_stamp <= '0;
                    r_prev_a     <= '0;
                    r_prev_b     <= '0;
                    r_prev_c     <= '0;
                    r_seen       <= '0;
                    r_next_grid  <= '0;
                end else begin
                    if (rem_needed) begin
                        r_next_grid <= {1'b0, r_lim} - {1'b0, r_rem} + {1'b0, per_eff};
                    end
                    r_prev_stamp <= r_rel;
                    r_prev_a     <= r_a;
                    r_prev_b     <= r_b;
                    r_prev_c     <= r_c;
                    if (r_seen != 2'd2) begin
                        r_seen <= r_seen + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_stamp <= i_stamp;
            r_a     <= i_chan_a;
            r_b     <= i_chan_b;
            r_c     <= i_chan_c;
            r_eos   <= i_end_of_stream;
        end
        if (i_cmd.calc_rel) begin
            r_rel  <= rel;
            r_span <= SPW'(per_eff) * SPW'(MAX_BURST);
        end
        if (i_cmd.calc_lim) begin
            r_den <= r_rel - r_prev_stamp;
            if (r_eos) begin
                r_lim <= r_end;
            end else if (r_seen != 2'd0 && r_rel != '0) begin
                r_lim <= (rel_m1 < r_end) ? rel_m1 : r_end;
            end else begin
                r_lim <= '0;
            end
        end
        if (i_cmd.calc_over) begin
            r_over <= r_have
                      && ((OW'(r_next_grid) + OW'(r_span)) <= OW'(r_lim));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_time <= t;
            r_o_last <= last;
            r_o_over <= r_over;
            if (use_in) begin
                r_o_a <= r_a;
                r_o_b <= r_b;
                r_o_c <= r_c;
            end else if (use_prev) begin
                r_o_a <= r_prev_a;
                r_o_b <= r_prev_b;
                r_o_c <= r_prev_c;
            end else begin
                r_o_a <= res_a;
                r_o_b <= res_b;
                r_o_c <= res_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_busy <= 1'b0;
            r_rcnt     <= '0;
        end else if (i_cmd.rem_start) begin
            r_rem_busy <= 1'b1;
            r_rcnt     <= RCW'(TW);
        end else if (r_rem_busy) begin
            r_rcnt <= r_rcnt - 1'b1;
            if (r_rcnt == RCW'(1)) begin
                r_rem_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rem_start) begin
            r_div <= r_lim - t;
            r_rem <= '0;
        end else if (r_rem_busy) begin
            r_div <= {r_div[TW-2:0], 1'b0};
            if (rem_x >= {1'b0, per_eff}) begin
                r_rem <= TW'(rem_x - {1'b0, per_eff});
            end else begin
                r_rem <= rem_x[TW-1:0];
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_grid_time      = r_o_time;
    assign o_out_a          = r_o_a;
    assign o_out_b          = r_o_b;
    assign o_out_c          = r_o_c;
    assign o_last_of_run    = r_o_last;
    assign o_burst_overflow = r_o_over;

endmodule

FILE: rtl/core/ugl_ctrl.sv
// Controller state machine of the resampler.
`timescale 1ns / 1ps

module ugl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ugl_pkg::t_status   i_status,
    output logic               o_in_ready,
    output ugl_pkg::t_cmd      o_cmd,
    output ugl_pkg::t_state    o_state
);
    ugl_pkg::t_state r_state;
    ugl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ugl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ugl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ugl_pkg::S_REL;
                end
            end
            ugl_pkg::S_REL: begin
                o_cmd.calc_rel = 1'b1;
                n_state        = ugl_pkg::S_LIM;
            end
            ugl_pkg::S_LIM: begin
                o_cmd.calc_lim = 1'b1;
                n_state        = ugl_pkg::S_OVER;
            end
            ugl_pkg::S_OVER: begin
                o_cmd.calc_over = 1'b1;
                n_state         = ugl_pkg::S_CHECK;
            end
            ugl_pkg::S_CHECK: begin
                if (i_status.point_ok) begin
                    if (i_status.need_interp) begin
                        o_cmd.lane_start = 1'b1;
                        n_state          = ugl_pkg::S_CALC;
                    end else begin
                        n_state = ugl_pkg::S_EMIT;
                    end
                end else if (i_status.rem_needed) begin
                    o_cmd.rem_start = 1'b1;
                    n_state         = ugl_pkg::S_REM;
                end else begin
                    n_state = ugl_pkg::S_FIN;
                end
            end
            ugl_pkg::S_CALC: begin
                if (i_status.lanes_done) begin
                    n_state = ugl_pkg::S_EMIT;
                end
            end
            ugl_pkg::S_EMIT: begin
                if (i_status.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ugl_pkg::S_CHECK;
                end
            end
            ugl_pkg::S_REM: begin
                if (i_status.rem_done) begin
                    n_state = ugl_pkg::S_FIN;
                end
            end
            ugl_pkg::S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ugl_pkg::S_IDLE;
            end
            default: begin
                n_state = ugl_pkg::S_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

FILE: rtl/core/uniform_grid_linear_resampler.sv
// Top level of the uniform grid linear resampler.
`timescale 1ns / 1ps

// Takes one timestamped three-channel sample at a time and emits grid points of
// the configured period, each copied from a sample or interpolated between the
// previous and current one in three bit-serial multiply-divide lanes. Setup runs
// through REL, LIM and OVER, each grid point is then checked and emitted, and FIN
// ends the sample; a run cut off at MAX_BURST points that does not end the stream
// runs the one-bit-per-cycle remainder loop that skips the rest. The next sample
// is accepted once the previous one has finished, while its last result may still
// wait in the output register. Configuration writes are taken in every cycle.

module uniform_grid_linear_resampler #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_BURST   = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ugl_sample_if.sink   i_sample,
    ugl_result_if.source o_result,
    ugl_cfg_if.sink      i_cfg
);
    ugl_pkg::t_cmd    cmd;
    ugl_pkg::t_status status;
    ugl_pkg::t_state  state;
    logic             in_ready;
    logic             out_valid;
    logic [ugl_pkg::TIME_W-1:0] grid_time;
    logic [VALUE_WIDTH-1:0]     out_a;
    logic [VALUE_WIDTH-1:0]     out_b;
    logic [VALUE_WIDTH-1:0]     out_c;
    logic                       last_of_run;
    logic                       burst_overflow;

    ugl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    ugl_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_BURST   (MAX_BURST)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_stamp          (i_sample.stamp),
        .i_chan_a         (i_sample.chan_a),
        .i_chan_b         (i_sample.chan_b),
        .i_chan_c         (i_sample.chan_c),
        .i_end_of_stream  (i_sample.end_of_stream),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (out_valid),
        .o_grid_time      (grid_time),
        .o_out_a          (out_a),
        .o_out_b          (out_b),
        .o_out_c          (out_c),
        .o_last_of_run    (last_of_run),
        .o_burst_overflow (burst_overflow)
    );

    assign i_sample.ready          = in_ready;
    assign i_cfg.ready             = 1'b1;
    assign o_result.valid          = out_valid;
    assign o_result.grid_time      = grid_time;
    assign o_result.out_a          = out_a;
    assign o_result.out_b          = out_b;
    assign o_result.out_c          = out_c;
    assign o_result.last_of_run    = last_of_run;
    assign o_result.burst_overflow = burst_overflow;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> (state == ugl_pkg::S_REL))
        else $error("accepted item did not start setup");

    a_emit_lanes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == ugl_pkg::S_EMIT) |-> status.lanes_done)
        else $error("emit while lanes still busy");

    a_check_rem_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == ugl_pkg::S_CHECK) |-> status.rem_done)
        else $error("remainder loop busy during point check");

    a_emit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_result.valid)
        else $error("emitted item missing at output");

endmodule

FILE: verif/uniform_grid_linear_resampler_tb.sv
// Self-checking testbench of the uniform grid linear resampler.
`timescale 1ns / 1ps

module uniform_grid_linear_resampler_tb;

    localparam int VW         = 32;
    localparam int BURST      = 64;
    localparam int SETTLE     = 300;
    localparam int CYCLE_CAP  = 3000000;
    localparam int RAND_ITEMS = 194;
    localparam logic [ugl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [31:0]   grid_time;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic [VW-1:0] c;
        logic          last;
        logic          ovf;
    } t_grid_point;

    logic i_clk;
    logic i_rst_n;

    ugl_sample_if #(.VALUE_WIDTH(VW)) sample_ch ();
    ugl_result_if #(.VALUE_WIDTH(VW)) result_ch ();
    ugl_cfg_if                        cfg_ch ();

    uniform_grid_linear_resampler #(.VALUE_WIDTH(VW), .MAX_BURST(BURST)) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_result (result_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    logic [63:0] m_period, m_start, m_end;
    logic [63:0] m_prev_t, m_prev_a, m_prev_b, m_prev_c, m_next;
    int          m_seen;

    t_grid_point pending_points[$];
    int          mismatches;
    int          points_checked;
    int          samples_sent;
    int          cfg_writes;
    int          cycles;
    int          ready_hold;
    bit          point_taken;
    bit          ready_steady;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [63:0] sext(logic [VW-1:0] v);
        return {{(64 - VW){v[VW-1]}}, v};
    endfunction

    function automatic logic [63:0] scale_round(logic [63:0] mag, logic [63:0] dt,
                                                logic [63:0] den);
        logic [127:0] prod;
        prod = {64'd0, mag} * {64'd0, dt} + {65'd0, den[63:1]};
        prod = prod / {64'd0, den};
        return prod[63:0];
    endfunction

    function automatic logic [63:0] lerp(logic [63:0] v0, logic [63:0] v1,
                                         logic [63:0] dt, logic [63:0] den);
        if (den == 0 || dt >= den) return v0;
        if ($signed(v1) >= $signed(v0)) return v0 + scale_round(v1 - v0, dt, den);
        return v0 - scale_round(v0 - v1, dt, den);
    endfunction

    task automatic predict_grid_points(logic [31:0] stamp, logic [VW-1:0] ia,
                                       logic [VW-1:0] ib, logic [VW-1:0] ic, logic eos);
        logic [63:0] per, rel, lim, t, dt, den, va, vb, vc, a, b, c, cnt;
        bit          have, over;
        int          n;
        t_grid_point gp;
        a = sext(ia);
        b = sext(ib);
        c = sext(ic);
        per = (m_period == 0) ? 64'd1 : m_period;
        rel = ({32'd0, stamp} < m_start) ? 64'd0 : {32'd0, stamp} - m_start;
        lim = 0;
        cnt = 0;
        have = 0;
        n = 0;
        if (m_seen > 0 && rel < m_prev_t) rel = m_prev_t;
        if (eos) begin
            lim = m_end;
            have = 1;
        end else if (m_seen > 0 && rel > 0) begin
            lim = (rel - 1 < m_end) ? rel - 1 : m_end;
            have = 1;
        end
        if (have && m_next <= lim) cnt = (lim - m_next) / per + 1;
        over = cnt > BURST;
        while (have && n < BURST && m_next <= lim) begin
            t = m_next;
            if (m_seen == 0 || t >= rel) begin
                va = a; vb = b; vc = c;
            end else if (m_seen == 1) begin
                va = m_prev_a; vb = m_prev_b; vc = m_prev_c;
            end else begin
                dt = (t >= m_prev_t) ? t - m_prev_t : 64'd0;
                den = rel - m_prev_t;
                va = lerp(m_prev_a, a, dt, den);
                vb = lerp(m_prev_b, b, dt, den);
                vc = lerp(m_prev_c, c, dt, den);
            end
            gp.grid_time = t[31:0];
            gp.a = va[VW-1:0];
            gp.b = vb[VW-1:0];
            gp.c = vc[VW-1:0];
            gp.last = 1'b0;
            gp.ovf = over;
            pending_points.push_back(gp);
            n++;
            m_next = t + per;
        end
        if (n > 0) pending_points[pending_points.size() - 1].last = 1'b1;
        if (eos) begin
            m_prev_t = 0; m_prev_a = 0; m_prev_b = 0; m_prev_c = 0;
            m_seen = 0;
            m_next = 0;
        end else begin
            if (have && m_next <= lim) m_next += ((lim - m_next) / per + 1) * per;
            m_prev_t = rel;
            m_prev_a = a; m_prev_b = b; m_prev_c = c;
            if (m_seen < 2) m_seen++;
        end
    endtask

    task automatic send_sample(logic [31:0] stamp, logic [VW-1:0] a, logic [VW-1:0] b,
                               logic [VW-1:0] c, logic eos);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap > 0) begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.stamp = stamp;
        sample_ch.chan_a = a;
        sample_ch.chan_b = b;
        sample_ch.chan_c = c;
        sample_ch.end_of_stream = eos;
        sample_ch.valid = 1'b1;
        do @(posedge i_clk); while (!sample_ch.ready);
        predict_grid_points(stamp, a, b, c, eos);
        samples_sent++;
    endtask

    task automatic drain;
        @(negedge i_clk);
        sample_ch.valid = 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ugl_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        drain();
        @(negedge i_clk);
        cfg_ch.index = idx;
        cfg_ch.data = data;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == ugl_pkg::REG_SAMPLE_PERIOD) m_period = {32'd0, data};
        else if (idx == ugl_pkg::REG_START_TIME) m_start = {32'd0, data};
        else if (idx == ugl_pkg::REG_END_TIME) m_end = {32'd0, data};
        cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_grid_point want;
        point_taken = 1'b0;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            point_taken = 1'b1;
            points_checked++;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected grid point t=%0d", result_ch.grid_time);
            end else begin
                want = pending_points.pop_front();
                if (result_ch.grid_time !== want.grid_time || result_ch.out_a !== want.a ||
                    result_ch.out_b !== want.b || result_ch.out_c !== want.c ||
                    result_ch.last_of_run !== want.last ||
                    result_ch.burst_overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp t=%0d a=%h b=%h c=%h last=%b ovf=%b",
                                 want.grid_time, want.a, want.b, want.c, want.last,
                                 want.ovf);
                        $display("          got t=%0d a=%h b=%h c=%h last=%b ovf=%b",
                                 result_ch.grid_time, result_ch.out_a,
                                 result_ch.out_b, result_ch.out_c,
                                 result_ch.last_of_run, result_ch.burst_overflow);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            result_ch.ready = 1'b0;
        end else begin
            if (point_taken && !ready_steady) begin
                ready_hold = $urandom_range(0, 14);
                if ($urandom_range(0, 7) == 0) ready_steady = 1'b1;
            end else if (point_taken && $urandom_range(0, 20) == 0) begin
                ready_steady = 1'b0;
            end
            result_ch.ready = (ready_hold == 0);
        end
    end

    task automatic test_interpolation;
        write_reg(ugl_pkg::REG_SAMPLE_PERIOD, 32'd1000);
        write_reg(ugl_pkg::REG_END_TIME, 32'd10000);
        send_sample(32'd0, 32'h7fffffff, 32'h80000000, 32'h00010000, 1'b0);
        send_sample(32'd2500, 32'h80000000, 32'h7fffffff, 32'hffff0000, 1'b0);
        send_sample(32'd2500, 32'h00000001, 32'h00000000, 32'hffffffff, 1'b0);
        send_sample(32'd1000, 32'h12345678, 32'hedcba987, 32'h00000000, 1'b0);
        send_sample(32'd7000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b0);
        send_sample(32'd8333, 32'h00000003, 32'hfffffffd, 32'h00008000, 1'b1);
    endtask

    task automatic test_special_cases;
        write_reg(ugl_pkg::REG_START_TIME, 32'd500);
        write_reg(REG_UNUSED, 32'hffffffff);
        send_sample(32'd100, 32'h00000010, 32'h00000020, 32'h00000030, 1'b1);
        send_sample(32'd100, 32'h00000011, 32'h00000021, 32'h00000031, 1'b0);
        send_sample(32'd4600, 32'h00000100, 32'h00000200, 32'h00000300, 1'b0);
        write_reg(ugl_pkg::REG_END_TIME, 32'd2000);
        send_sample(32'd9000, 32'h00001000, 32'h00002000, 32'h00003000, 1'b1);
        write_reg(ugl_pkg::REG_SAMPLE_PERIOD, 32'd0);
        write_reg(ugl_pkg::REG_START_TIME, 32'hffffffff);
        write_reg(ugl_pkg::REG_END_TIME, 32'd5);
        send_sample(32'hffffffff, 32'hfffffffe, 32'h00000001, 32'h55555555, 1'b0);
        send_sample(32'h00000000, 32'haaaaaaaa, 32'h00000002, 32'h55555555, 1'b1);
    endtask

    task automatic test_burst_cap;
        write_reg(ugl_pkg::REG_START_TIME, 32'd0);
        write_reg(ugl_pkg::REG_SAMPLE_PERIOD, 32'd1);
        write_reg(ugl_pkg::REG_END_TIME, 32'd200);
        send_sample(32'd0, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0);
        send_sample(32'd150, 32'h00960000, 32'hff6a0000, 32'h00000007, 1'b0);
        send_sample(32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000002, 1'b1);
        write_reg(ugl_pkg::REG_SAMPLE_PERIOD, 32'hffffffff);
        write_reg(ugl_pkg::REG_END_TIME, 32'hffffffff);
        send_sample(32'd7, 32'h00000000, 32'h7fffffff, 32'h80000000, 1'b1);
    endtask

    task automatic test_random_streams;
        logic [63:0] per, rel;
        logic [31:0] va, vb, vc;
        int          len, sent;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0: per = 64'd0;
                1: per = 64'd1;
                2: per = 64'hffffffff;
                3: per = {32'd0, $urandom_range(2, 20)};
                default: per = {32'd0, $urandom_range(50, 5000)};
            endcase
            write_reg(ugl_pkg::REG_SAMPLE_PERIOD, per[31:0]);
            if (per == 0) per = 64'd1;
            case ($urandom_range(0, 5))
                0: write_reg(ugl_pkg::REG_START_TIME, 32'd0);
                1: write_reg(ugl_pkg::REG_START_TIME,
                             $urandom_range(32'hffff0000, 32'hffffffff));
                default: write_reg(ugl_pkg::REG_START_TIME, $urandom);
            endcase
            if (per == 64'hffffffff || $urandom_range(0, 9) == 0)
                write_reg(ugl_pkg::REG_END_TIME, $urandom);
            else
                write_reg(ugl_pkg::REG_END_TIME,
                          32'(per * 64'($urandom_range(0, 30))
                              + 64'($urandom_range(0, 3))));
            len = $urandom_range(1, 8);
            rel = $urandom_range(0, 1) ? 64'd0 : per * 64'($urandom_range(0, 3));
            va = $urandom; vb = $urandom; vc = $urandom;
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0 && rel > 0)
                    rel = rel - 64'($urandom_range(0, 100));
                else
                    rel = rel + per * 64'($urandom_range(0, 6))
                          + 64'($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) begin
                    va = va + $urandom_range(0, 20) - 10;
                    vb = vb + $urandom_range(0, 20) - 10;
                    vc = vc + $urandom_range(0, 20) - 10;
                end else begin
                    va = $urandom; vb = $urandom; vc = $urandom;
                end
                send_sample(m_start[31:0] + rel[31:0], va, vb, vc, k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        m_period = {32'd0, ugl_pkg::RESET_SAMPLE_PERIOD};
        m_start = 0; m_end = 0;
        m_prev_t = 0; m_prev_a = 0; m_prev_b = 0; m_prev_c = 0;
        m_next = 0; m_seen = 0;
        mismatches = 0; points_checked = 0; samples_sent = 0; cfg_writes = 0;
        cycles = 0; ready_hold = 0; point_taken = 0; ready_steady = 0;
        i_rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.stamp = '0;
        sample_ch.chan_a = '0;
        sample_ch.chan_b = '0;
        sample_ch.chan_c = '0;
        sample_ch.end_of_stream = 1'b0;
        result_ch.ready = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_interpolation();
        test_special_cases();
        test_burst_cap();
        test_random_streams();
        drain();

        $display("Sent %0d samples and %0d register writes; checked %0d grid points.",
                 samples_sent, cfg_writes, points_checked);
        if (pending_points.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

FILE: uniform_grid_linear_resampler.f
rtl/core/ugl_pkg.sv
rtl/core/ugl_sample_if.sv
rtl/core/ugl_result_if.sv
rtl/core/ugl_cfg_if.sv
rtl/core/ugl_lane.sv
rtl/core/ugl_datapath.sv
rtl/core/ugl_ctrl.sv
rtl/core/uniform_grid_linear_resampler.sv
verif/uniform_grid_linear_resampler_tb.sv
